[rtl/core/frd_pkg.sv]
// frd_pkg: widths, payload types and unit status shared by the fraction reducer.
// No dependencies; used by frd_gcd, frd_div and fraction_reducer.

package frd_pkg;

    localparam int VALUE_W = 32;
    localparam int MAG_W   = VALUE_W - 1;
    localparam int SHIFT_W = $clog2(MAG_W);
    localparam int COUNT_W = $clog2(MAG_W + 1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] num_in;
        logic signed [VALUE_W-1:0] den_in;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] num_out;
        logic [MAG_W-1:0]          den_out;
        logic                      is_whole;
        logic                      zero_den_error;
    } rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

[rtl/core/frd_gcd.sv]
// frd_gcd: binary greatest common divisor, one subtract/shift step per cycle.
// Depends on frd_pkg. Operand b must be nonzero at start.

module frd_gcd (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [frd_pkg::MAG_W-1:0] a,
    input  logic [frd_pkg::MAG_W-1:0] b,
    output logic [frd_pkg::MAG_W-1:0] gcd,
    output frd_pkg::unit_stat_t     stat
);

    logic [frd_pkg::MAG_W-1:0]   a_reg, a_next;
    logic [frd_pkg::MAG_W-1:0]   b_reg, b_next;
    logic [frd_pkg::SHIFT_W-1:0] k_reg, k_next;
    logic [frd_pkg::MAG_W-1:0]   g_reg, g_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [frd_pkg::MAG_W-1:0]   a_minus_b;
    logic [frd_pkg::MAG_W-1:0]   b_minus_a;
    logic                        a_ge_b;

    // one shared subtractor pair; only one difference is kept per step
    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;
    assign a_ge_b    = (a_reg >= b_reg);

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            priority if (a_reg == '0)
            begin
                // b stays nonzero throughout, so it holds the odd part
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_ge_b)
            begin
                a_next = a_minus_b >> 1;
            end
            else
            begin
                b_next = b_minus_a >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign gcd       = g_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/core/frd_div.sv]
// frd_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on frd_pkg. Divisor must be nonzero at start.

module frd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [frd_pkg::MAG_W-1:0] dividend,
    input  logic [frd_pkg::MAG_W-1:0] divisor,
    output logic [frd_pkg::MAG_W-1:0] quotient,
    output frd_pkg::unit_stat_t       stat
);

    logic [frd_pkg::MAG_W-1:0]   q_reg, q_next;
    logic [frd_pkg::MAG_W-1:0]   rem_reg, rem_next;
    logic [frd_pkg::MAG_W-1:0]   dvs_reg, dvs_next;
    logic [frd_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [frd_pkg::MAG_W:0]     rem_shift;
    logic [frd_pkg::MAG_W:0]     trial;

    assign rem_shift = {rem_reg, q_reg[frd_pkg::MAG_W-1]};
    assign trial     = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = frd_pkg::COUNT_W'(frd_pkg::MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // borrow out means the trial went negative: restore
            if (trial[frd_pkg::MAG_W])
            begin
                rem_next = rem_shift[frd_pkg::MAG_W-1:0];
                q_next   = {q_reg[frd_pkg::MAG_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[frd_pkg::MAG_W-1:0];
                q_next   = {q_reg[frd_pkg::MAG_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == frd_pkg::COUNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/core/fraction_reducer.sv]
// fraction_reducer: reduces a signed fraction to lowest terms.
// Depends on frd_pkg, frd_gcd and frd_div.
//
//   channel | valid     | stall     | payload              | dir
//   --------+-----------+-----------+----------------------+-----
//   request | req_valid | req_stall | req_data  (req_t)    | in
//   result  | rsp_valid | rsp_stall | rsp_data  (rsp_t)    | out
//
// One request at a time: binary GCD, one step per cycle, then the shared divider
// runs twice. A zero denominator skips the arithmetic and goes to S_DONE.
// req_stall is high from acceptance until the result is in the output register;
// a held result under rsp_stall blocks only the final load.
// rst_n clears the sequencer and valid flags asynchronously.

module fraction_reducer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  frd_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output frd_pkg::rsp_t rsp_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                      neg;
        logic [frd_pkg::MAG_W-1:0] mag;
    } split_t;

    // sign and magnitude; the most negative code saturates one step toward zero
    function automatic split_t split_signed(input logic [frd_pkg::VALUE_W-1:0] v);
        split_t                      s;
        logic [frd_pkg::VALUE_W-1:0] full;
        s.neg = v[frd_pkg::VALUE_W-1];
        full  = s.neg ? (~v + 1'b1) : v;
        s.mag = full[frd_pkg::VALUE_W-1] ? '1 : full[frd_pkg::MAG_W-1:0];
        return s;
    endfunction

    state_t                    state_reg, state_next;
    logic                      n_neg_reg, n_neg_next;
    logic                      d_neg_reg, d_neg_next;
    logic [frd_pkg::MAG_W-1:0] n_mag_reg, n_mag_next;
    logic [frd_pkg::MAG_W-1:0] d_mag_reg, d_mag_next;
    logic [frd_pkg::MAG_W-1:0] rn_reg, rn_next;
    logic [frd_pkg::MAG_W-1:0] rd_reg, rd_next;
    logic                      err_reg, err_next;
    logic                      gcd_start_reg, gcd_start_next;
    logic                      div_start_reg, div_start_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    frd_pkg::rsp_t             rsp_reg, rsp_next;

    split_t                    n_split;
    split_t                    d_split;
    logic                      req_take;
    logic                      slot_free;
    logic                      negative;
    logic [frd_pkg::VALUE_W-1:0] rn_wide;
    logic [frd_pkg::MAG_W-1:0] gcd_value;
    logic [frd_pkg::MAG_W-1:0] div_dividend;
    logic [frd_pkg::MAG_W-1:0] div_quotient;
    frd_pkg::unit_stat_t       gcd_stat;
    frd_pkg::unit_stat_t       div_stat;

    frd_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start_reg),
        .a     (n_mag_reg),
        .b     (d_mag_reg),
        .gcd   (gcd_value),
        .stat  (gcd_stat)
    );

    // first pass divides the numerator, second the denominator
    assign div_dividend = (state_reg == S_DIVD) ? d_mag_reg : n_mag_reg;

    frd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (gcd_value),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign n_split   = split_signed(req_data.num_in);
    assign d_split   = split_signed(req_data.den_in);
    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign negative  = (rn_reg != '0) && (n_neg_reg != d_neg_reg);
    assign rn_wide   = {1'b0, rn_reg};

    always_comb
    begin
        state_next     = state_reg;
        n_neg_next     = n_neg_reg;
        d_neg_next     = d_neg_reg;
        n_mag_next     = n_mag_reg;
        d_mag_next     = d_mag_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        err_next       = err_reg;
        gcd_start_next = 1'b0;
        div_start_next = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    n_neg_next = n_split.neg;
                    d_neg_next = d_split.neg;
                    n_mag_next = n_split.mag;
                    d_mag_next = d_split.mag;
                    if (d_split.mag == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        err_next       = 1'b0;
                        gcd_start_next = 1'b1;
                        state_next     = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (gcd_stat.done)
                begin
                    div_start_next = 1'b1;
                    state_next     = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_stat.done)
                begin
                    rn_next        = div_quotient;
                    div_start_next = 1'b1;
                    state_next     = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_stat.done)
                begin
                    rd_next    = div_quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    if (err_reg)
                    begin
                        rsp_next.num_out        = '0;
                        rsp_next.den_out        = '0;
                        rsp_next.is_whole       = 1'b0;
                        rsp_next.zero_den_error = 1'b1;
                    end
                    else
                    begin
                        rsp_next.num_out        = negative ? (~rn_wide + 1'b1) : rn_wide;
                        rsp_next.den_out        = rd_reg;
                        rsp_next.is_whole       = (rd_reg == frd_pkg::MAG_W'(1));
                        rsp_next.zero_den_error = 1'b0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gcd_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gcd_start_reg <= gcd_start_next;
            div_start_reg <= div_start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_neg_reg <= n_neg_next;
        d_neg_reg <= d_neg_next;
        n_mag_reg <= n_mag_next;
        d_mag_reg <= d_mag_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        err_reg   <= err_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
